[src/lobm_pkg.sv]
// Package with the transaction types and result codes of the order book matcher.
package lobm_pkg;

	localparam int PRICE_W = 31;
	localparam int VOL_W   = 24;
	localparam int OID_W   = 24;

	localparam logic [2:0] RK_ID       = 3'd0;
	localparam logic [2:0] RK_TRADE    = 3'd1;
	localparam logic [2:0] RK_DELETED  = 3'd2;
	localparam logic [2:0] RK_NOTFOUND = 3'd3;
	localparam logic [2:0] RK_REJECT   = 3'd4;

	localparam logic KIND_ADD = 1'b0;
	localparam logic KIND_DEL = 1'b1;

	localparam logic SIDE_SELL = 1'b0;
	localparam logic SIDE_BUY  = 1'b1;

	// Matching stops after this many trades for one add.
	localparam int MAX_TRADES = 16;

	typedef struct packed {
		logic               kind;
		logic               side;
		logic [PRICE_W-1:0] limit_price;
		logic [VOL_W-1:0]   order_volume;
		logic [OID_W-1:0]   target_id;
	} cmd_t;

	typedef struct packed {
		logic [2:0]         result_kind;
		logic [OID_W-1:0]   assigned_id;
		logic [OID_W-1:0]   buyer_id;
		logic [OID_W-1:0]   seller_id;
		logic [PRICE_W-1:0] trade_price;
		logic [VOL_W-1:0]   trade_volume;
		logic               last;
	} res_t;

	// Controller to datapath commands.
	typedef struct packed {
		logic load;       // capture the command and clear the trade count
		logic scan_clr;   // reset the scan pointer and best holder
		logic scan_step;  // examine one entry
		logic [1:0] scan_mode; // which scan runs
		logic do_insert;  // store the new order
		logic do_trade;   // apply the trade to the two orders
		logic do_delete;  // clear the found entry
		logic hold;       // build a new result into the hold register
		logic emit;       // present the held result
		logic [2:0] emit_kind; // kind of the result being built
		logic emit_last;  // last flag of the presented result
	} ctl_t;

	// Datapath to controller status.
	typedef struct packed {
		logic scan_done;  // pointer is at the last entry
		logic found;      // current scan found an entry
		logic ids_out;    // id counter exhausted
		logic vol_zero;   // add volume is zero
		logic is_del;
	} sts_t;

	localparam logic [1:0] SM_FREE = 2'd0; // find free entry or delete target
	localparam logic [1:0] SM_BEST = 2'd1; // highest buy
	localparam logic [1:0] SM_SELL = 2'd2; // oldest crossing sell
	localparam logic [1:0] SM_BUY  = 2'd3; // oldest crossing buy

endpackage

[src/lobm_datapath.sv]
// Datapath of the order book matcher: book registers, entry scan and trade arithmetic.
module lobm_datapath #(
	parameter int BOOK_DEPTH = 16,
	parameter int ID_BITS    = 24
) (
	input  logic            clk,
	input  logic            arst_n,
	input  lobm_pkg::cmd_t  cmd,
	input  lobm_pkg::ctl_t  ctl,
	output lobm_pkg::sts_t  sts,
	output lobm_pkg::res_t  res,
	output logic            res_valid
);
	import lobm_pkg::*;

	localparam int IW = (BOOK_DEPTH > 1) ? $clog2(BOOK_DEPTH) : 1;
	localparam logic [IW-1:0] LAST_IDX = IW'(BOOK_DEPTH - 1);
	localparam logic [ID_BITS-1:0] ID_LIMIT = {ID_BITS{1'b1}};

	logic [BOOK_DEPTH-1:0] valid_q;
	logic                  side_q  [BOOK_DEPTH];
	logic [ID_BITS-1:0]    id_q    [BOOK_DEPTH];
	logic [PRICE_W-1:0]    price_q [BOOK_DEPTH];
	logic [VOL_W-1:0]      vol_q   [BOOK_DEPTH];
	logic [ID_BITS-1:0]    ctr_q;

	cmd_t            cmd_q;
	logic [IW-1:0]   ptr_q;
	logic            hit_q;
	logic [IW-1:0]   hit_idx_q;
	logic [IW-1:0]   sell_q;
	logic [IW-1:0]   buy_q;
	logic [PRICE_W-1:0] best_price_q;
	res_t            hold_q;
	res_t            res_q;
	logic            res_valid_q;

	logic cand;
	logic better;
	logic [VOL_W-1:0] amount;
	logic [PRICE_W-1:0] tprice;
	logic [ID_BITS-1:0] next_id;
	res_t res_n;
	res_t res_e;

	// Candidate test for the entry under the pointer.
	always_comb begin
		cand   = 1'b0;
		better = 1'b0;
		unique case (ctl.scan_mode)
			SM_FREE: begin
				if (cmd_q.kind == KIND_DEL) begin
					cand = valid_q[ptr_q] && (32'(id_q[ptr_q]) == 32'(cmd_q.target_id));
				end else begin
					cand = !valid_q[ptr_q];
				end
				better = !hit_q;
			end
			SM_BEST: begin
				cand   = valid_q[ptr_q] && side_q[ptr_q] == SIDE_BUY;
				better = !hit_q || price_q[ptr_q] > best_price_q;
			end
			SM_SELL: begin
				cand   = valid_q[ptr_q] && side_q[ptr_q] == SIDE_SELL
					&& price_q[ptr_q] <= best_price_q;
				better = !hit_q || id_q[ptr_q] < id_q[hit_idx_q];
			end
			SM_BUY: begin
				cand   = valid_q[ptr_q] && side_q[ptr_q] == SIDE_BUY
					&& price_q[ptr_q] >= price_q[sell_q];
				better = !hit_q || id_q[ptr_q] < id_q[hit_idx_q];
			end
			default: begin
				cand   = 1'b0;
				better = 1'b0;
			end
		endcase
	end

	assign amount = (vol_q[sell_q] < vol_q[buy_q]) ? vol_q[sell_q] : vol_q[buy_q];
	assign tprice = (price_q[buy_q] > price_q[sell_q] && id_q[sell_q] < id_q[buy_q])
		? price_q[sell_q] : price_q[buy_q];
	assign next_id = ctr_q + 1'b1;

	// New result to be held, and the held result as it leaves with its last flag.
	always_comb begin
		res_n = '0;
		res_n.result_kind = ctl.emit_kind;
		unique case (ctl.emit_kind)
			RK_ID:      res_n.assigned_id = OID_W'({8'd0, next_id});
			RK_DELETED: res_n.assigned_id = cmd_q.target_id;
			RK_TRADE: begin
				res_n.buyer_id     = OID_W'({8'd0, id_q[buy_q]});
				res_n.seller_id    = OID_W'({8'd0, id_q[sell_q]});
				res_n.trade_price  = tprice;
				res_n.trade_volume = amount;
			end
			default: ;
		endcase
		res_e      = hold_q;
		res_e.last = ctl.emit_last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q     <= '0;
			ctr_q       <= '0;
			ptr_q       <= '0;
			hit_q       <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			res_valid_q <= ctl.emit;
			if (ctl.load) begin
				cmd_q <= cmd;
			end
			if (ctl.scan_clr) begin
				ptr_q <= '0;
				hit_q <= 1'b0;
			end else if (ctl.scan_step) begin
				if (ptr_q != LAST_IDX) begin
					ptr_q <= ptr_q + 1'b1;
				end
				if (cand && better) begin
					hit_q     <= 1'b1;
					hit_idx_q <= ptr_q;
					if (ctl.scan_mode == SM_BEST) begin
						best_price_q <= price_q[ptr_q];
					end
					if (ctl.scan_mode == SM_SELL) begin
						sell_q <= ptr_q;
					end
					if (ctl.scan_mode == SM_BUY) begin
						buy_q <= ptr_q;
					end
				end
			end
			if (ctl.do_insert) begin
				ctr_q <= next_id;
				if (cmd_q.order_volume != '0) begin
					valid_q[hit_idx_q] <= 1'b1;
					side_q[hit_idx_q]  <= cmd_q.side;
					id_q[hit_idx_q]    <= next_id;
					price_q[hit_idx_q] <= cmd_q.limit_price;
					vol_q[hit_idx_q]   <= cmd_q.order_volume;
				end
			end
			if (ctl.do_delete) begin
				valid_q[hit_idx_q] <= 1'b0;
			end
			if (ctl.do_trade) begin
				vol_q[sell_q] <= vol_q[sell_q] - amount;
				vol_q[buy_q]  <= vol_q[buy_q] - amount;
				if (vol_q[sell_q] == amount) begin
					valid_q[sell_q] <= 1'b0;
				end
				if (vol_q[buy_q] == amount) begin
					valid_q[buy_q] <= 1'b0;
				end
			end
			if (ctl.hold) begin
				hold_q <= res_n;
			end
			if (ctl.emit) begin
				res_q <= res_e;
			end
		end
	end

	assign sts.scan_done = (ptr_q == LAST_IDX);
	assign sts.found     = hit_q;
	assign sts.ids_out   = (ctr_q == ID_LIMIT);
	assign sts.vol_zero  = (cmd_q.order_volume == '0);
	assign sts.is_del    = (cmd_q.kind == KIND_DEL);

	assign res       = res_q;
	assign res_valid = res_valid_q;

endmodule

[src/lobm_ctrl.sv]
// Controller state machine that sequences the scans, updates and results of the matcher.
module lobm_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  lobm_pkg::sts_t sts,
	output lobm_pkg::ctl_t ctl
);
	import lobm_pkg::*;

	localparam logic [3:0] ST_IDLE   = 4'd0;
	localparam logic [3:0] ST_FREE   = 4'd1;
	localparam logic [3:0] ST_DECIDE = 4'd2;
	localparam logic [3:0] ST_BEST   = 4'd3;
	localparam logic [3:0] ST_SELL0  = 4'd4;
	localparam logic [3:0] ST_SELL   = 4'd5;
	localparam logic [3:0] ST_BUY0   = 4'd6;
	localparam logic [3:0] ST_BUY    = 4'd7;
	localparam logic [3:0] ST_TRADE  = 4'd8;
	localparam logic [3:0] ST_BEST0  = 4'd9;
	localparam logic [3:0] ST_FINAL  = 4'd10;

	localparam int TW = $clog2(MAX_TRADES + 1);

	logic [3:0]    state_q, state_d;
	logic [TW-1:0] trades_q;

	// Each result waits in the hold register until the next one is known, so that
	// its last flag is right when it is presented.
	always_comb begin
		state_d = state_q;
		ctl     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					ctl.load     = 1'b1;
					ctl.scan_clr = 1'b1;
					state_d      = ST_FREE;
				end
			end
			ST_FREE: begin
				ctl.scan_mode = SM_FREE;
				ctl.scan_step = 1'b1;
				if (sts.scan_done) state_d = ST_DECIDE;
			end
			ST_DECIDE: begin
				ctl.hold     = 1'b1;
				ctl.scan_clr = 1'b1;
				state_d      = ST_FINAL;
				if (sts.is_del) begin
					ctl.emit_kind = sts.found ? RK_DELETED : RK_NOTFOUND;
					ctl.do_delete = sts.found;
				end else if (sts.ids_out || (!sts.vol_zero && !sts.found)) begin
					ctl.emit_kind = RK_REJECT;
				end else begin
					ctl.emit_kind = RK_ID;
					ctl.do_insert = 1'b1;
					state_d       = sts.vol_zero ? ST_FINAL : ST_BEST;
				end
			end
			ST_BEST: begin
				ctl.scan_mode = SM_BEST;
				ctl.scan_step = 1'b1;
				if (sts.scan_done) state_d = ST_SELL0;
			end
			ST_SELL0: begin
				ctl.scan_clr = 1'b1;
				state_d = sts.found ? ST_SELL : ST_FINAL;
			end
			ST_SELL: begin
				ctl.scan_mode = SM_SELL;
				ctl.scan_step = 1'b1;
				if (sts.scan_done) state_d = ST_BUY0;
			end
			ST_BUY0: begin
				ctl.scan_clr = 1'b1;
				state_d = sts.found ? ST_BUY : ST_FINAL;
			end
			ST_BUY: begin
				ctl.scan_mode = SM_BUY;
				ctl.scan_step = 1'b1;
				if (sts.scan_done) state_d = ST_TRADE;
			end
			ST_TRADE: begin
				// Present the held result, then this trade becomes the held one.
				ctl.emit      = 1'b1;
				ctl.hold      = 1'b1;
				ctl.emit_kind = RK_TRADE;
				ctl.do_trade  = 1'b1;
				ctl.scan_clr  = 1'b1;
				state_d = (trades_q == TW'(MAX_TRADES - 1)) ? ST_FINAL : ST_BEST0;
			end
			ST_BEST0: begin
				ctl.scan_clr = 1'b1;
				state_d = ST_BEST;
			end
			ST_FINAL: begin
				ctl.emit      = 1'b1;
				ctl.emit_last = 1'b1;
				state_d       = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			trades_q <= '0;
		end else begin
			state_q <= state_d;
			if (ctl.load) begin
				trades_q <= '0;
			end
			if (ctl.do_trade) begin
				trades_q <= trades_q + 1'b1;
			end
		end
	end

	assign busy = (state_q != ST_IDLE);

endmodule

[src/limit_order_book_matcher.sv]
// Top level of the limit order book matcher.
// Usage: a command transaction is taken at a clock edge with start high and busy low.
// The command is an add (side, limit price, volume) or a delete (target id).
// Every command produces one or more result transactions on result, each marked
// by result_valid for exactly one cycle; result.last flags the final one.
// An add first reports its id (or a reject), then one trade per match, at most
// sixteen trades. A delete reports deleted or not found.
// Timing: every scan walks the book registers one entry per cycle.
// A delete, a reject or a zero volume add needs only the free-entry scan before its
// result, and busy drops once that result has been shown. Each trade costs three
// scans (best buy, crossing sell, crossing buy); the closing check that finds nothing
// to cross costs at most two scans. Sixteen trades end without the closing check.
// Results are held one step so the last flag is known when a result appears.
// The receiver cannot stall: results are presented once and must be taken.
// Reset clears all valid bits and the id counter; the first id is 1.
// busy stays high from acceptance until the final result has been presented.
module limit_order_book_matcher #(
	parameter int BOOK_DEPTH = 16,
	parameter int ID_BITS    = 24
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  lobm_pkg::cmd_t cmd,
	output lobm_pkg::res_t result,
	output logic           result_valid
);
	import lobm_pkg::*;

	ctl_t ctl;
	sts_t sts;
	logic busy_c;

	// A command is not taken while the final result of the previous one is shown.
	lobm_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start && !result_valid),
		.busy   (busy_c),
		.sts    (sts),
		.ctl    (ctl)
	);

	lobm_datapath #(
		.BOOK_DEPTH (BOOK_DEPTH),
		.ID_BITS    (ID_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.ctl       (ctl),
		.sts       (sts),
		.res       (result),
		.res_valid (result_valid)
	);

	// Busy also covers the cycle in which the final result is shown.
	assign busy = busy_c || result_valid;

	a_no_accept_when_out: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.last |-> busy)
		else $error("result stream ended early");
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.last |=> !result_valid)
		else $error("result after last");
	a_kind_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> result.result_kind <= RK_REJECT)
		else $error("bad result kind");

endmodule
